@@ rtl/hsv2rgb_pkg.sv @@
// hsv2rgb_pkg: constants, class codes and helper functions for the hsv to rgb pixel pipeline
// no dependencies; imported by the interfaces, hsv2rgb_div and hsv_to_rgb_pixel
package hsv2rgb_pkg;

  localparam int CHANNEL_BITS_DEF = 16;
  localparam int CFG_BITS         = 24;
  localparam int SAMPLE_BITS      = 18;
  localparam int CLASS_BITS       = 3;

  localparam int TURN       = 36000;
  localparam int SECTOR     = 6000;
  localparam int ONE_Q16    = 65536;
  localparam int HALF_Q16   = 32768;
  localparam int TURN_BIAS  = 4 * TURN;
  localparam int DQ         = ONE_Q16 * SECTOR;
  localparam int DQ_HALF    = DQ / 2;
  localparam int SCALE_RST  = 65536;

  // floor(2^32 / 375) for the level divide
  localparam int DIV_BY     = 375;
  localparam int DIV_MAGIC  = 11453246;

  typedef enum logic [CLASS_BITS-1:0] {
    CLS_NORMAL     = 3'd0,
    CLS_NULL       = 3'd1,
    CLS_LOW_INSTR  = 3'd2,
    CLS_LOW_REPR   = 3'd3,
    CLS_HIGH_REPR  = 3'd4,
    CLS_HIGH_INSTR = 3'd5
  } pix_class_t;

  typedef struct packed {
    logic mul_en;
    logic fix_en;
  } div_en_t;

  function automatic logic signed [SAMPLE_BITS-1:0] class_force(
    input logic [CLASS_BITS-1:0]         cls,
    input logic signed [SAMPLE_BITS-1:0] raw,
    input logic signed [SAMPLE_BITS-1:0] high
  );
    logic signed [SAMPLE_BITS-1:0] res;
    unique case (cls)
      CLS_NULL, CLS_LOW_INSTR, CLS_LOW_REPR: res = '0;
      CLS_HIGH_REPR, CLS_HIGH_INSTR:         res = high;
      default:                               res = raw;
    endcase
    return res;
  endfunction

  function automatic logic [16:0] clamp_unit(input logic signed [SAMPLE_BITS-1:0] x);
    logic [16:0] res;
    if (x < 0) begin
      res = '0;
    end else if (x > SAMPLE_BITS'(ONE_Q16)) begin
      res = 17'(ONE_Q16);
    end else begin
      res = x[16:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/hsv2rgb_if.sv @@
// hsv2rgb_in_if and hsv2rgb_out_if: valid/ready channels of the hsv to rgb pipeline
// depends on hsv2rgb_pkg
interface hsv2rgb_in_if import hsv2rgb_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] hue_deg;
  logic [CLASS_BITS-1:0]         hue_class;
  logic signed [SAMPLE_BITS-1:0] sat_in;
  logic [CLASS_BITS-1:0]         sat_class;
  logic signed [SAMPLE_BITS-1:0] val_in;
  logic [CLASS_BITS-1:0]         val_class;

  modport source(output valid, hue_deg, hue_class, sat_in, sat_class, val_in, val_class,
                 input ready);
  modport sink(input valid, hue_deg, hue_class, sat_in, sat_class, val_in, val_class,
               output ready);
endinterface

interface hsv2rgb_out_if import hsv2rgb_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_out;
  logic [CHANNEL_BITS-1:0] green_out;
  logic [CHANNEL_BITS-1:0] blue_out;
  logic                    value_clipped;

  modport source(output valid, red_out, green_out, blue_out, value_clipped, input ready);
  modport sink(input valid, red_out, green_out, blue_out, value_clipped, output ready);
endinterface

@@ rtl/hsv2rgb_div.sv @@
// hsv2rgb_div: two-stage divide by 375 (reciprocal multiply, then one correction step)
// depends on hsv2rgb_pkg
module hsv2rgb_div import hsv2rgb_pkg::*; (
  input  logic        clk,
  input  div_en_t     en,
  input  logic [24:0] num,
  output logic [16:0] quo
);

  logic [48:0] prod;
  logic [24:0] num_r;
  logic [16:0] est_r;
  logic [25:0] back;
  logic [24:0] rem;
  logic [16:0] quo_r;
  logic [16:0] quo_nxt;

  assign prod = 49'(num) * 49'(DIV_MAGIC);

  always_ff @(posedge clk) begin
    if (en.mul_en) begin
      num_r <= num;
      est_r <= prod[48:32];
    end
    if (en.fix_en) begin
      quo_r <= quo_nxt;
    end
  end

  // estimate is exact or one low
  always_comb begin
    back    = 26'(est_r) * 26'(DIV_BY);
    rem     = num_r - back[24:0];
    quo_nxt = (rem >= 25'(DIV_BY)) ? est_r + 17'd1 : est_r;
  end

  assign quo = quo_r;

endmodule

@@ rtl/hsv_to_rgb_pixel.sv @@
// hsv_to_rgb_pixel: eight-stage hsv to rgb pixel converter with brightness scale register
// depends on hsv2rgb_pkg, hsv2rgb_if and hsv2rgb_div
//
//   port     dir  flow          contents
//   in_ch    in   valid/ready   hue, saturation, value samples and their classes
//   out_ch   out  valid/ready   red, green, blue channels and value clip flag
//   cfg_*    in   write enable  value_scale, unsigned q8.16
//
// one pixel per cycle while out_ch takes results; a result is valid on out_ch once the pixel
// has passed through every stage register, the output reg last
// stages: class/clamp/hue wrap, scale multiply, level products, level multiplies,
// rounding, divide by 375 (two stages), sector select and channel scaling into the output reg
// each stage holds when full and the next one cannot take, so bubbles close up under stall
// rst_n clears the stage valids and sets value_scale to 1.0
module hsv_to_rgb_pixel import hsv2rgb_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  hsv2rgb_in_if.sink          in_ch,
  hsv2rgb_out_if.source       out_ch,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata
);

  localparam int NSTG = 8;
  localparam int PW   = 17 + CHANNEL_BITS + 1;

  logic [CFG_BITS-1:0] scale_r;
  logic [NSTG:1]       vld_r;
  logic [NSTG+1:1]     rdy;

  // stage 1
  logic signed [SAMPLE_BITS-1:0] h_f, s_f, v_f;
  logic [18:0] h_b, h_sel;
  logic [15:0] h1_r;
  logic [16:0] sq1_r, vq1_r;
  // stage 2
  logic [2:0]  sec_c;
  logic [15:0] fr_c;
  logic [40:0] prod2_r;
  logic [2:0]  sec2_r;
  logic [12:0] f2_r;
  logic [16:0] sq2_r;
  // stage 3
  logic [41:0] rnd3;
  logic [29:0] sqf_c, sqt_c;
  logic [16:0] vs3_r, ns3_r;
  logic        clip3_r;
  logic [28:0] sqf3_r, sqt3_r;
  logic [2:0]  sec3_r;
  // stage 4
  logic [28:0] aq_c, at_c;
  logic [45:0] xq4_r, xt4_r;
  logic [33:0] xp4_r;
  logic [16:0] vs4_r;
  logic        clip4_r;
  logic [2:0]  sec4_r;
  // stage 5
  logic [46:0] sq5, st5;
  logic [34:0] sp5;
  logic [24:0] zq5_r, zt5_r;
  logic [16:0] lp5_r, vs5_r;
  logic        clip5_r;
  logic [2:0]  sec5_r;
  // stages 6 and 7
  logic [16:0] lp6_r, vs6_r, lp7_r, vs7_r;
  logic        clip6_r, clip7_r;
  logic [2:0]  sec6_r, sec7_r;
  logic [16:0] lq7, lt7;
  div_en_t     div_en;
  // stage 8
  logic [16:0] r_c, g_c, b_c;
  logic [CHANNEL_BITS-1:0] red_r, green_r, blue_r;
  logic        clip8_r;

  function automatic logic [CHANNEL_BITS-1:0] chan_scale(input logic [16:0] c);
    logic [PW-1:0] ext;
    logic [PW-1:0] acc;
    ext = PW'(c);
    acc = (ext << CHANNEL_BITS) - ext + PW'(HALF_Q16);
    return acc[16 +: CHANNEL_BITS];
  endfunction

  always_comb begin
    rdy[NSTG+1] = out_ch.ready;
    for (int i = NSTG; i >= 1; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign in_ch.ready = rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      scale_r <= CFG_BITS'(SCALE_RST);
    end else begin
      if (cfg_we) begin
        scale_r <= cfg_wdata;
      end
      for (int i = 1; i <= NSTG; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= (i == 1) ? in_ch.valid : vld_r[i-1];
        end
      end
    end
  end

  // class replace, clamp, hue wrap into one turn
  always_comb begin
    h_f = class_force(in_ch.hue_class, in_ch.hue_deg, SAMPLE_BITS'(TURN));
    s_f = class_force(in_ch.sat_class, in_ch.sat_in, SAMPLE_BITS'(ONE_Q16));
    v_f = class_force(in_ch.val_class, in_ch.val_in, SAMPLE_BITS'(ONE_Q16));
    h_b = 19'(19'(signed'(h_f)) + 19'(TURN_BIAS));
    h_sel = h_b;
    for (int t = 1; t <= 7; t++) begin
      if (h_b >= 19'(t * TURN)) begin
        h_sel = h_b - 19'(t * TURN);
      end
    end
  end

  // sector and fraction
  always_comb begin
    sec_c = '0;
    fr_c  = h1_r;
    for (int t = 1; t <= 5; t++) begin
      if (h1_r >= 16'(t * SECTOR)) begin
        sec_c = 3'(t);
        fr_c  = h1_r - 16'(t * SECTOR);
      end
    end
  end

  always_comb begin
    rnd3  = 42'(prod2_r) + 42'(HALF_Q16);
    sqf_c = 30'(sq2_r) * 30'(f2_r);
    sqt_c = 30'(sq2_r) * 30'(13'(SECTOR) - f2_r);
    aq_c  = 29'(DQ) - sqf3_r;
    at_c  = 29'(DQ) - sqt3_r;
    sq5   = 47'(xq4_r) + 47'(DQ_HALF);
    st5   = 47'(xt4_r) + 47'(DQ_HALF);
    sp5   = 35'(xp4_r) + 35'(HALF_Q16);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      h1_r  <= h_sel[15:0];
      sq1_r <= clamp_unit(s_f);
      vq1_r <= clamp_unit(v_f);
    end
    if (rdy[2]) begin
      prod2_r <= 41'(vq1_r) * 41'(scale_r);
      sec2_r  <= sec_c;
      f2_r    <= fr_c[12:0];
      sq2_r   <= sq1_r;
    end
    if (rdy[3]) begin
      clip3_r <= prod2_r > (41'(ONE_Q16) << 16);
      vs3_r   <= (prod2_r > (41'(ONE_Q16) << 16)) ? 17'(ONE_Q16) : rnd3[32:16];
      ns3_r   <= 17'(ONE_Q16) - sq2_r;
      sqf3_r  <= sqf_c[28:0];
      sqt3_r  <= sqt_c[28:0];
      sec3_r  <= sec2_r;
    end
    if (rdy[4]) begin
      xq4_r   <= 46'(vs3_r) * 46'(aq_c);
      xt4_r   <= 46'(vs3_r) * 46'(at_c);
      xp4_r   <= 34'(vs3_r) * 34'(ns3_r);
      vs4_r   <= vs3_r;
      clip4_r <= clip3_r;
      sec4_r  <= sec3_r;
    end
    if (rdy[5]) begin
      zq5_r   <= sq5[44:20];
      zt5_r   <= st5[44:20];
      lp5_r   <= sp5[32:16];
      vs5_r   <= vs4_r;
      clip5_r <= clip4_r;
      sec5_r  <= sec4_r;
    end
    if (rdy[6]) begin
      lp6_r   <= lp5_r;
      vs6_r   <= vs5_r;
      clip6_r <= clip5_r;
      sec6_r  <= sec5_r;
    end
    if (rdy[7]) begin
      lp7_r   <= lp6_r;
      vs7_r   <= vs6_r;
      clip7_r <= clip6_r;
      sec7_r  <= sec6_r;
    end
    if (rdy[8]) begin
      red_r   <= chan_scale(r_c);
      green_r <= chan_scale(g_c);
      blue_r  <= chan_scale(b_c);
      clip8_r <= clip7_r;
    end
  end

  assign div_en = '{mul_en: rdy[6], fix_en: rdy[7]};

  hsv2rgb_div u_div_q (
    .clk (clk),
    .en  (div_en),
    .num (zq5_r),
    .quo (lq7)
  );

  hsv2rgb_div u_div_t (
    .clk (clk),
    .en  (div_en),
    .num (zt5_r),
    .quo (lt7)
  );

  always_comb begin
    unique case (sec7_r)
      3'd0: begin
        r_c = vs7_r; g_c = lt7;   b_c = lp7_r;
      end
      3'd1: begin
        r_c = lq7;   g_c = vs7_r; b_c = lp7_r;
      end
      3'd2: begin
        r_c = lp7_r; g_c = vs7_r; b_c = lt7;
      end
      3'd3: begin
        r_c = lp7_r; g_c = lq7;   b_c = vs7_r;
      end
      3'd4: begin
        r_c = lt7;   g_c = lp7_r; b_c = vs7_r;
      end
      default: begin
        r_c = vs7_r; g_c = lp7_r; b_c = lq7;
      end
    endcase
  end

  assign out_ch.valid         = vld_r[NSTG];
  assign out_ch.red_out       = red_r;
  assign out_ch.green_out     = green_r;
  assign out_ch.blue_out      = blue_r;
  assign out_ch.value_clipped = clip8_r;

endmodule
